[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL in this folder.
// Needs a clock named clk and an active-low reset named arst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset
`define PSF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication
`define PSF_ASSERT_IMP(label, ante, cons, msg) \
	`PSF_ASSERT(label, (ante) |-> (cons), msg)

`endif

[rtl/core/psf_pkg.sv]
// Shared widths, constants and types of the pendulum state-feedback core.
// No dependencies; imported by psf_cmd, pendulum_state_feedback_core and tb_top.
package psf_pkg;

	// Field widths
	localparam int ANGLE_W   = 16;
	localparam int SPEED_W   = 20;
	localparam int GAIN_W    = 24;
	localparam int ERR_W     = ANGLE_W + 1;
	localparam int CMD_W     = 17;
	localparam int DIST_W    = 15;
	localparam int CFG_IDX_W = 4;

	// Gain format and output clamp
	localparam int GAIN_FRACTION_BITS = 16;
	localparam int OUTPUT_LIMIT       = 40000;

	// Datapath widths: widest product, four-term sum plus negation headroom
	localparam int PROD_W = GAIN_W + SPEED_W;
	localparam int SUM_W  = PROD_W + 3;
	localparam int SHR_W  = SUM_W - GAIN_FRACTION_BITS;

	localparam logic signed [SHR_W-1:0] SHR_LIMIT = SHR_W'(OUTPUT_LIMIT);
	localparam logic signed [CMD_W-1:0] CMD_LIMIT = CMD_W'(OUTPUT_LIMIT);

	// Angle geometry in centidegrees
	localparam logic signed [ERR_W-1:0]  HALF_TURN  = ERR_W'(18000);
	localparam logic signed [ERR_W:0]    FULL_TURN  = (ERR_W + 1)'(36000);
	localparam logic        [DIST_W-1:0] NEAR_LIMIT = DIST_W'(1500);
	localparam logic        [DIST_W-1:0] DIST_MAX   = DIST_W'(18000);

	// Gain register file
	localparam int GAIN_COUNT = 8;
	localparam int REG_W      = $clog2(GAIN_COUNT);

	typedef enum logic [REG_W-1:0] {
		REG_M1_PEND_ANGLE,
		REG_M1_PEND_RATE,
		REG_M1_WHEEL_ANGLE,
		REG_M1_WHEEL_RATE,
		REG_M2_PEND_ANGLE,
		REG_M2_PEND_RATE,
		REG_M2_WHEEL_ANGLE,
		REG_M2_WHEEL_RATE
	} gain_reg_t;

	localparam logic signed [GAIN_W-1:0] GAIN_RESET [GAIN_COUNT] = '{
		24'sd46267, 24'sd140930, 24'sd0, 24'sd0,
		24'sd0,     24'sd0,      24'sd1807, 24'sd143058
	};

	// One command's four gains
	typedef struct packed {
		logic signed [GAIN_W-1:0] pend_angle;
		logic signed [GAIN_W-1:0] pend_rate;
		logic signed [GAIN_W-1:0] wheel_angle;
		logic signed [GAIN_W-1:0] wheel_rate;
	} gain_row_t;

	// Feedback operands shared by both commands
	typedef struct packed {
		logic signed [ERR_W-1:0]   pend_err;
		logic signed [SPEED_W-1:0] pend_rate;
		logic signed [ANGLE_W-1:0] wheel_angle;
		logic signed [SPEED_W-1:0] wheel_rate;
	} operand_t;

endpackage

[rtl/core/psf_cmd.sv]
// One motor command: four registered gain products, then sum, negate, shift, clamp.
// Depends on psf_pkg.
module psf_cmd (
	input  logic                               clk,
	input  logic                               en,
	input  psf_pkg::operand_t                  op,
	input  psf_pkg::gain_row_t                 gains,
	output logic signed [psf_pkg::CMD_W-1:0]   cmd
);
	import psf_pkg::*;

	logic signed [PROD_W-1:0] prod_pa, prod_pr, prod_wa, prod_wr;
	logic signed [PROD_W-1:0] prod_pa_s2, prod_pr_s2, prod_wa_s2, prod_wr_s2;
	logic signed [SUM_W-1:0]  sum, neg_sum;
	logic signed [SHR_W-1:0]  shr;

	// Four independent multipliers
	assign prod_pa = gains.pend_angle  * op.pend_err;
	assign prod_pr = gains.pend_rate   * op.pend_rate;
	assign prod_wa = gains.wheel_angle * op.wheel_angle;
	assign prod_wr = gains.wheel_rate  * op.wheel_rate;

	// Product register
	always_ff @(posedge clk) begin
		if (en) begin
			prod_pa_s2 <= prod_pa;
			prod_pr_s2 <= prod_pr;
			prod_wa_s2 <= prod_wa;
			prod_wr_s2 <= prod_wr;
		end
	end

	// Negated sum, floor shift (arithmetic), clamp to the limit
	always_comb begin
		sum = SUM_W'(prod_pa_s2) + SUM_W'(prod_pr_s2) + SUM_W'(prod_wa_s2)
			+ SUM_W'(prod_wr_s2);
		neg_sum = -sum;
		shr = $signed(neg_sum[SUM_W-1:GAIN_FRACTION_BITS]);
		if (shr > SHR_LIMIT) begin
			cmd = SHR_LIMIT[CMD_W-1:0];
		end else if (shr < -SHR_LIMIT) begin
			cmd = CMD_W'(-SHR_LIMIT);
		end else begin
			cmd = shr[CMD_W-1:0];
		end
	end

endmodule

[rtl/core/pendulum_state_feedback_core.sv]
// Top level of the pendulum state-feedback core: gain registers, pipeline, upright check.
// Depends on psf_pkg, psf_cmd and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one sample: pendulum angle and speed,
//   flywheel angle and speed. Output channel (out_valid/out_ready) returns the two
//   clamped motor speed commands, the distance to upright and the near-upright flag.
//   Gains are written through cfg_we/cfg_index/cfg_data while the core is idle;
//   indexes past the last gain are ignored.
//   Results pass through the input register, the product register and the result
//   register in that order before out_valid rises. Throughput: one sample per cycle
//   while out_ready stays high; the eight 24-bit multipliers sit in parallel in the
//   product stage.
//   Each stage holds its item while the next is full, so a stalled receiver
//   backs up the pipeline one stage at a time; in_ready drops once all three
//   stages hold data and out_ready is low. Nothing is dropped or repeated.
//   Reset empties the pipeline and loads the default gains.
module pendulum_state_feedback_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Gain write port
	input  logic                                 cfg_we,
	input  logic [psf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic signed [psf_pkg::GAIN_W-1:0]    cfg_data,
	// Sample channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [psf_pkg::ANGLE_W-1:0]   pendulum_angle,
	input  logic signed [psf_pkg::SPEED_W-1:0]   pendulum_speed,
	input  logic signed [psf_pkg::ANGLE_W-1:0]   flywheel_angle,
	input  logic signed [psf_pkg::SPEED_W-1:0]   flywheel_speed,
	// Command channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [psf_pkg::CMD_W-1:0]     pendulum_motor_speed,
	output logic signed [psf_pkg::CMD_W-1:0]     flywheel_motor_speed,
	output logic [psf_pkg::DIST_W-1:0]           upright_distance,
	output logic                                 near_upright
);
	import psf_pkg::*;
`include "assert_macros.svh"

	logic signed [GAIN_W-1:0] gain_q [GAIN_COUNT];

	logic                       v_s1, v_s2, v_s3;
	logic                       rdy1, rdy2, rdy3;
	logic                       adv2, adv3;
	logic signed [ANGLE_W-1:0]  pangle_s1, fangle_s1;
	logic signed [SPEED_W-1:0]  pspeed_s1, fspeed_s1;
	logic [DIST_W-1:0]          dist_s2, dist_s3;
	logic                       near_s2, near_s3;
	logic signed [CMD_W-1:0]    cmd1, cmd2, cmd1_s3, cmd2_s3;

	operand_t                   op;
	gain_row_t                  row1, row2;
	logic signed [ERR_W:0]      wrapped;
	logic [ERR_W-1:0]           mag;
	logic [DIST_W-1:0]          upright_dist;

	// Gain registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < GAIN_COUNT; i++) gain_q[i] <= GAIN_RESET[i];
		end else if (cfg_we && (cfg_index < CFG_IDX_W'(GAIN_COUNT))) begin
			gain_q[cfg_index[REG_W-1:0]] <= cfg_data;
		end
	end

	assign row1 = '{gain_q[REG_M1_PEND_ANGLE], gain_q[REG_M1_PEND_RATE],
		gain_q[REG_M1_WHEEL_ANGLE], gain_q[REG_M1_WHEEL_RATE]};
	assign row2 = '{gain_q[REG_M2_PEND_ANGLE], gain_q[REG_M2_PEND_RATE],
		gain_q[REG_M2_WHEEL_ANGLE], gain_q[REG_M2_WHEEL_RATE]};

	// Stage handshake: a stage takes new data when empty or when it drains
	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;
	assign adv2     = v_s1 && rdy2;
	assign adv3     = v_s2 && rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			pangle_s1 <= pendulum_angle;
			pspeed_s1 <= pendulum_speed;
			fangle_s1 <= flywheel_angle;
			fspeed_s1 <= flywheel_speed;
		end
	end

	// Angle error against the upright on the same side
	always_comb begin
		op.pend_err    = (pangle_s1 >= 0) ? ERR_W'(pangle_s1) - HALF_TURN
			: ERR_W'(pangle_s1) + HALF_TURN;
		op.pend_rate   = pspeed_s1;
		op.wheel_angle = fangle_s1;
		op.wheel_rate  = fspeed_s1;
	end

	psf_cmd u_cmd1 (
		.clk   (clk),
		.en    (adv2),
		.op    (op),
		.gains (row1),
		.cmd   (cmd1)
	);

	psf_cmd u_cmd2 (
		.clk   (clk),
		.en    (adv2),
		.op    (op),
		.gains (row2),
		.cmd   (cmd2)
	);

	// Upright distance: one wrap step covers the whole 16-bit angle range
	always_comb begin
		wrapped = (ERR_W + 1)'(pangle_s1);
		if (wrapped > (ERR_W + 1)'(HALF_TURN)) begin
			wrapped = wrapped - FULL_TURN;
		end else if (wrapped < -((ERR_W + 1)'(HALF_TURN))) begin
			wrapped = wrapped + FULL_TURN;
		end
		mag          = (wrapped < 0) ? ERR_W'(-wrapped) : ERR_W'(wrapped);
		upright_dist = DIST_MAX - mag[DIST_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			dist_s2 <= upright_dist;
			near_s2 <= (upright_dist < NEAR_LIMIT);
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (adv3) begin
			cmd1_s3 <= cmd1;
			cmd2_s3 <= cmd2;
			dist_s3 <= dist_s2;
			near_s3 <= near_s2;
		end
	end

	assign out_valid            = v_s3;
	assign pendulum_motor_speed = cmd1_s3;
	assign flywheel_motor_speed = cmd2_s3;
	assign upright_distance     = dist_s3;
	assign near_upright         = near_s3;

	// Checks
	`PSF_ASSERT_IMP(a_cmd1_clamped, out_valid,
		(pendulum_motor_speed <= CMD_LIMIT) && (pendulum_motor_speed >= -CMD_LIMIT),
		"pendulum command beyond limit")
	`PSF_ASSERT_IMP(a_cmd2_clamped, out_valid,
		(flywheel_motor_speed <= CMD_LIMIT) && (flywheel_motor_speed >= -CMD_LIMIT),
		"flywheel command beyond limit")
	`PSF_ASSERT_IMP(a_near_flag, out_valid,
		near_upright == (upright_distance < NEAR_LIMIT), "near flag disagrees with distance")
	`PSF_ASSERT_IMP(a_dist_range, out_valid, upright_distance <= DIST_MAX,
		"upright distance out of range")
	`PSF_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready,
		"input stalled while result stage empty")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for pendulum_state_feedback_core: random and directed sensor
// readings, gain table rewrites between phases. Depends on psf_pkg and the core RTL.
module tb_top;
	import psf_pkg::*;

	localparam int TURN_HALF    = 18000;
	localparam int TURN_FULL    = 36000;
	localparam int NEAR_CD      = 1500;
	localparam int SPEED_SPAN   = 360000;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_HOLD    = 80;
	localparam int STALL_LIMIT  = 4000;
	localparam int PHASE_COUNT  = 6;
	localparam int PHASE_ITEMS  = 155;

	localparam logic signed [GAIN_W-1:0] GAIN_TOP    = {1'b0, {(GAIN_W-1){1'b1}}};
	localparam logic signed [GAIN_W-1:0] GAIN_BOTTOM = {1'b1, {(GAIN_W-1){1'b0}}};

	typedef struct packed {
		logic signed [ANGLE_W-1:0] pend_angle;
		logic signed [SPEED_W-1:0] pend_speed;
		logic signed [ANGLE_W-1:0] wheel_angle;
		logic signed [SPEED_W-1:0] wheel_speed;
	} reading_t;

	typedef struct packed {
		logic signed [CMD_W-1:0] pend_cmd;
		logic signed [CMD_W-1:0] wheel_cmd;
		logic [DIST_W-1:0]       up_dist;
		logic                    near_flag;
	} motor_result_t;

	// Expected-command store with its own copy of the gain table
	class feedback_scoreboard;
		longint gain_q [GAIN_COUNT];
		motor_result_t expected_cmds [$];
		int failures;

		function new();
			foreach (gain_q[i]) gain_q[i] = GAIN_RESET[i];
			failures = 0;
		endfunction

		function void set_gain(logic [CFG_IDX_W-1:0] idx, logic signed [GAIN_W-1:0] value);
			if (idx < GAIN_COUNT)
				gain_q[idx] = value;
		endfunction

		// Negated dot product, floor shift, clamp
		function longint motor_command(longint g_err, longint g_prate, longint g_wang,
				longint g_wrate, longint err, reading_t r);
			longint acc;
			longint cmd;
			acc = g_err * err + g_prate * longint'($signed(r.pend_speed))
				+ g_wang * longint'($signed(r.wheel_angle))
				+ g_wrate * longint'($signed(r.wheel_speed));
			cmd = (-acc) >>> GAIN_FRACTION_BITS;
			if (cmd > OUTPUT_LIMIT)
				cmd = OUTPUT_LIMIT;
			if (cmd < -OUTPUT_LIMIT)
				cmd = -OUTPUT_LIMIT;
			return cmd;
		endfunction

		function void note_reading(reading_t r);
			motor_result_t res;
			longint ang;
			longint err;
			longint c1;
			longint c2;
			ang = $signed(r.pend_angle);
			err = (ang >= 0) ? ang - TURN_HALF : ang + TURN_HALF;
			c1 = motor_command(gain_q[REG_M1_PEND_ANGLE], gain_q[REG_M1_PEND_RATE],
				gain_q[REG_M1_WHEEL_ANGLE], gain_q[REG_M1_WHEEL_RATE], err, r);
			c2 = motor_command(gain_q[REG_M2_PEND_ANGLE], gain_q[REG_M2_PEND_RATE],
				gain_q[REG_M2_WHEEL_ANGLE], gain_q[REG_M2_WHEEL_RATE], err, r);
			// distance to the nearest upright after wrapping into one turn
			if (ang > TURN_HALF)
				ang = ang - TURN_FULL;
			if (ang < -TURN_HALF)
				ang = ang + TURN_FULL;
			if (ang < 0)
				ang = -ang;
			res.pend_cmd  = CMD_W'(c1);
			res.wheel_cmd = CMD_W'(c2);
			res.up_dist   = DIST_W'(TURN_HALF - ang);
			res.near_flag = (TURN_HALF - ang) < NEAR_CD;
			expected_cmds.push_back(res);
		endfunction

		function void compare_field(string name, longint want, longint got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
				failures++;
			end
		endfunction

		function void check_result(motor_result_t got);
			motor_result_t want;
			if (expected_cmds.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %h", $time, got);
				failures++;
				return;
			end
			want = expected_cmds.pop_front();
			compare_field("pendulum_motor_speed", want.pend_cmd, got.pend_cmd);
			compare_field("flywheel_motor_speed", want.wheel_cmd, got.wheel_cmd);
			compare_field("upright_distance", want.up_dist, got.up_dist);
			compare_field("near_upright", want.near_flag, got.near_flag);
		endfunction

		function int pending();
			return expected_cmds.size();
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic signed [GAIN_W-1:0]   cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic signed [ANGLE_W-1:0]  pendulum_angle = '0;
	logic signed [SPEED_W-1:0]  pendulum_speed = '0;
	logic signed [ANGLE_W-1:0]  flywheel_angle = '0;
	logic signed [SPEED_W-1:0]  flywheel_speed = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [CMD_W-1:0]    pendulum_motor_speed;
	logic signed [CMD_W-1:0]    flywheel_motor_speed;
	logic [DIST_W-1:0]          upright_distance;
	logic                       near_upright;

	feedback_scoreboard sb = new();

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	logic signed [GAIN_W-1:0] gain_plan [GAIN_COUNT];

	pendulum_state_feedback_core DUT (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_we               (cfg_we),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.in_valid             (in_valid),
		.in_ready             (in_ready),
		.pendulum_angle       (pendulum_angle),
		.pendulum_speed       (pendulum_speed),
		.flywheel_angle       (flywheel_angle),
		.flywheel_speed       (flywheel_speed),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.pendulum_motor_speed (pendulum_motor_speed),
		.flywheel_motor_speed (flywheel_motor_speed),
		.upright_distance     (upright_distance),
		.near_upright         (near_upright)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Transfers and gain writes seen at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.set_gain(cfg_index, cfg_data);
			if (in_valid && in_ready)
				sb.note_reading({pendulum_angle, pendulum_speed, flywheel_angle, flywheel_speed});
			if (out_valid && out_ready)
				sb.check_result({pendulum_motor_speed, flywheel_motor_speed,
					upright_distance, near_upright});
		end
	end

	// Receiver: random stalls, plus long hold-offs on request
	initial begin : receiver
		int hold_left;
		int holds_served;
		hold_left = 0;
		holds_served = 0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && holds_served != hold_requests) begin
				holds_served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog on cycles with no transfer and no gain write
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	function automatic reading_t make_reading(int pa, int ps, int wa, int ws);
		reading_t r;
		r.pend_angle  = ANGLE_W'(pa);
		r.pend_speed  = SPEED_W'(ps);
		r.wheel_angle = ANGLE_W'(wa);
		r.wheel_speed = SPEED_W'(ws);
		return r;
	endfunction

	// Angles: half in range, some full width, some at the upright and near-upright edges
	function automatic int random_angle();
		int sgn;
		sgn = $urandom_range(1) ? 1 : -1;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return int'($urandom_range(2 * TURN_HALF)) - TURN_HALF;
			5, 6:          return int'($urandom);
			7:             return sgn * (TURN_HALF + int'($urandom_range(4)) - 2);
			default:       return sgn * (TURN_HALF - NEAR_CD + int'($urandom_range(4)) - 2);
		endcase
	endfunction

	function automatic int random_speed();
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: return int'($urandom_range(2 * SPEED_SPAN)) - SPEED_SPAN;
			6, 7, 8:          return int'($urandom);
			default:          return int'($urandom_range(2000)) - 1000;
		endcase
	endfunction

	task automatic send_reading(input reading_t r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		pendulum_angle <= r.pend_angle;
		pendulum_speed <= r.pend_speed;
		flywheel_angle <= r.wheel_angle;
		flywheel_speed <= r.wheel_speed;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Rewrite the whole gain table, then poke an index past the last gain
	task automatic apply_gain_plan();
		wait_drained();
		for (int i = 0; i < GAIN_COUNT; i++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_W'(gain_reg_t'(i));
			cfg_data  <= gain_plan[i];
		end
		@(negedge clk);
		cfg_index <= CFG_IDX_W'(GAIN_COUNT + $urandom_range((1 << CFG_IDX_W) - 1 - GAIN_COUNT));
		cfg_data  <= GAIN_W'($urandom);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		logic signed [GAIN_W-1:0] raw;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 33;
		recv_idle_pct = 83;

		// Directed readings under the default gains
		send_reading(make_reading(0, 0, 0, 0));
		send_reading(make_reading(TURN_HALF, 0, 0, 0));
		send_reading(make_reading(-TURN_HALF, 0, 0, 0));
		send_reading(make_reading(-1, 0, 0, 0));
		send_reading(make_reading(TURN_HALF - NEAR_CD, 0, 0, 0));
		send_reading(make_reading(TURN_HALF - NEAR_CD + 1, 0, 0, 0));
		send_reading(make_reading(-(TURN_HALF - NEAR_CD + 1), 0, 0, 0));
		send_reading(make_reading(TURN_HALF + 1, 0, 0, 0));
		send_reading(make_reading(-(TURN_HALF + 1), 0, 0, 0));
		send_reading(make_reading(32767, SPEED_SPAN, TURN_HALF, -SPEED_SPAN));
		send_reading(make_reading(-32768, -SPEED_SPAN, -TURN_HALF, SPEED_SPAN));
		send_reading(make_reading(0, 524287, 32767, 524287));
		send_reading(make_reading(0, -524288, -32768, -524288));
		send_reading(make_reading(17000, 100, -500, 200));
		send_reading(make_reading(-17000, -100, 500, -200));
		send_reading(make_reading(1, 1, 1, 1));

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			// Gain setting for this phase; the first keeps the defaults
			if (phase > 0) begin
				stop_sending();
				for (int i = 0; i < GAIN_COUNT; i++) begin
					case (phase)
						1: gain_plan[i] = GAIN_TOP;
						2: gain_plan[i] = GAIN_BOTTOM;
						3: gain_plan[i] = GAIN_W'(int'($urandom_range(8192)) - 4096);
						4: begin
							raw = GAIN_W'($urandom);
							gain_plan[i] = raw >>> $urandom_range(GAIN_W - 1);
						end
						default: begin
							case ($urandom_range(2))
								0: gain_plan[i] = '0;
								1: gain_plan[i] = GAIN_W'(int'($urandom_range(8192)) - 4096);
								default: gain_plan[i] = GAIN_RESET[i];
							endcase
						end
					endcase
				end
				apply_gain_plan();
			end

			// Idle pattern: sender-light, then receiver-light, then none
			case (phase / 2)
				0: begin
					send_idle_pct = 33;
					recv_idle_pct = 83;
				end
				1: begin
					send_idle_pct = 83;
					recv_idle_pct = 33;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// back-pressure burst: receiver holds off while readings keep coming
				if (phase == 4 && n == 50)
					hold_requests++;
				send_reading(make_reading(random_angle(), random_speed(),
					random_angle(), random_speed()));
			end
		end

		stop_sending();
		wait_drained();
		if (sb.failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/psf_pkg.sv
rtl/core/psf_cmd.sv
rtl/core/pendulum_state_feedback_core.sv
tb/tb_top.sv
